[sv/lrcv_pkg.sv]
package lrcv_pkg;

  // crc-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  // depth of the queue between parser front and record back end
  localparam int QUEUE_DEPTH = 2;

  // result kinds
  localparam logic [1:0] KIND_ID  = 2'd0;
  localparam logic [1:0] KIND_STR = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  // record field phases
  typedef enum logic [2:0] {
    PH_SEQ,
    PH_TYPE,
    PH_IDLEN,
    PH_ID,
    PH_VALUE,
    PH_STRLEN,
    PH_STR,
    PH_TAIL
  } phase_t;

  // one classified byte, handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    phase_t     ph;
    logic       crc_en;
    logic       last;
  } op_t;

  // one byte step of the reflected crc
  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

[sv/lrcv_if.sv]
// input byte channel
interface lrcv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] log_byte;
  logic       start_of_log;

  modport source (output valid, output log_byte, output start_of_log, input ready);
  modport sink   (input valid, input log_byte, input start_of_log, output ready);
endinterface

// result channel
interface lrcv_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic        [7:0]  data_byte;
  logic        [63:0] sequence_res;
  logic        [7:0]  entry_type;
  logic        [15:0] id_length;
  logic signed [63:0] int_value;
  logic        [15:0] string_length;
  logic        [63:0] timestamp_bits;
  logic               crc_ok;

  modport source (output valid, output kind, output data_byte, output sequence_res,
                  output entry_type, output id_length, output int_value,
                  output string_length, output timestamp_bits, output crc_ok,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input sequence_res,
                  input entry_type, input id_length, input int_value,
                  input string_length, input timestamp_bits, input crc_ok,
                  output ready);
endinterface

[sv/log_record_crc_verifier.sv]
// an accepted byte is written into the queue and then, if it yields a result,
// into the back end's output register, from which the output handshake takes it
// throughput: one byte per cycle; the back end's byte-wide crc step and the
// front's field counter each take one byte a cycle, a two-entry queue between;
// input stalls only while a held result leaves two bytes waiting in the queue
// reset: synchronous active low; clears parser phase, queue, halt flag and
// output valid, and sets the running crc to all ones
module log_record_crc_verifier (
  input  logic        clk,
  input  logic        rst_n,
  lrcv_in_if.sink     in_chan,
  lrcv_out_if.source  out_chan
);

  logic          q_push, q_pop, q_empty, q_full;
  lrcv_pkg::op_t push_op, pop_op;

  // byte parser and classifier
  lrcv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .push    (q_push),
    .push_op (push_op)
  );

  // decoupling queue
  lrcv_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .pop_op  (pop_op),
    .empty   (q_empty),
    .full    (q_full)
  );

  // crc, field capture and results
  lrcv_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .op       (pop_op),
    .pop      (q_pop),
    .out_chan (out_chan)
  );

  // queue never underflows or overflows
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("pop from empty queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("push into full queue");

  // record end is only flagged on a tail byte
  a_last_in_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && push_op.last) |-> (push_op.ph == lrcv_pkg::PH_TAIL && !push_op.crc_en))
    else $error("record end outside tail");

  // a popped id or string byte marked as record start leaves the output valid next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (pop_op.ph == lrcv_pkg::PH_ID || pop_op.ph == lrcv_pkg::PH_STR)
     && pop_op.start) |=> out_chan.valid)
    else $error("id or string byte lost");

endmodule

[sv/lrcv_front.sv]
module lrcv_front (
  input  logic             clk,
  input  logic             rst_n,
  lrcv_in_if.sink          in_chan,
  input  logic             q_full,
  output logic             push,
  output lrcv_pkg::op_t    push_op
);

  lrcv_pkg::phase_t ph_r, ph_nxt, eff_ph;
  logic [15:0]      cnt_r, cnt_nxt, eff_cnt, cnt_dec;
  logic [15:0]      len_r, len_nxt;
  logic [7:0]       b;

  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && !q_full;
  assign b             = in_chan.log_byte;

  // classify the byte and step the field counter
  always_comb begin
    eff_ph  = in_chan.start_of_log ? lrcv_pkg::PH_SEQ : ph_r;
    eff_cnt = in_chan.start_of_log ? 16'd0 : cnt_r;
    cnt_dec = (eff_cnt == 16'd0) ? 16'd0 : eff_cnt - 16'd1;
    ph_nxt  = eff_ph;
    cnt_nxt = eff_cnt + 16'd1;
    len_nxt = len_r;

    push_op.data   = b;
    push_op.start  = in_chan.start_of_log;
    push_op.ph     = eff_ph;
    push_op.crc_en = !(eff_ph == lrcv_pkg::PH_TAIL && eff_cnt >= 16'd8);
    push_op.last   = (eff_ph == lrcv_pkg::PH_TAIL && eff_cnt == 16'd11);

    case (eff_ph)
      lrcv_pkg::PH_SEQ: begin
        if (eff_cnt == 16'd7) begin
          ph_nxt  = lrcv_pkg::PH_TYPE;
          cnt_nxt = 16'd0;
        end
      end
      lrcv_pkg::PH_TYPE: begin
        ph_nxt  = lrcv_pkg::PH_IDLEN;
        cnt_nxt = 16'd0;
      end
      lrcv_pkg::PH_IDLEN, lrcv_pkg::PH_STRLEN: begin
        len_nxt = {b, len_r[15:8]};
        if (eff_cnt == 16'd1) begin
          cnt_nxt = len_nxt;
          if (len_nxt == 16'd0) begin
            ph_nxt = (eff_ph == lrcv_pkg::PH_IDLEN) ? lrcv_pkg::PH_VALUE
                                                    : lrcv_pkg::PH_TAIL;
          end else begin
            ph_nxt = (eff_ph == lrcv_pkg::PH_IDLEN) ? lrcv_pkg::PH_ID
                                                    : lrcv_pkg::PH_STR;
          end
        end
      end
      lrcv_pkg::PH_ID, lrcv_pkg::PH_STR: begin
        cnt_nxt = cnt_dec;
        if (cnt_dec == 16'd0) begin
          ph_nxt = (eff_ph == lrcv_pkg::PH_ID) ? lrcv_pkg::PH_VALUE : lrcv_pkg::PH_TAIL;
        end
      end
      lrcv_pkg::PH_VALUE: begin
        if (eff_cnt == 16'd7) begin
          ph_nxt  = lrcv_pkg::PH_STRLEN;
          cnt_nxt = 16'd0;
        end
      end
      lrcv_pkg::PH_TAIL: begin
        if (eff_cnt == 16'd11) begin
          ph_nxt  = lrcv_pkg::PH_SEQ;
          cnt_nxt = 16'd0;
        end
      end
      default: begin
        ph_nxt  = lrcv_pkg::PH_SEQ;
        cnt_nxt = 16'd0;
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= lrcv_pkg::PH_SEQ;
      cnt_r <= 16'd0;
    end else if (push) begin
      ph_r  <= ph_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // length assembly
  always_ff @(posedge clk) begin
    if (push) begin
      len_r <= len_nxt;
    end
  end

endmodule

[sv/lrcv_queue.sv]
module lrcv_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lrcv_pkg::op_t    push_op,
  input  logic             pop,
  output lrcv_pkg::op_t    pop_op,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (lrcv_pkg::QUEUE_DEPTH > 1) ? $clog2(lrcv_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(lrcv_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(lrcv_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(lrcv_pkg::QUEUE_DEPTH);

  lrcv_pkg::op_t    mem_r [lrcv_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  assign empty  = (cnt_r == '0);
  assign full   = (cnt_r == DEPTH_CNT);
  assign pop_op = mem_r[rd_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == LAST_PTR) ? '0 : wr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == LAST_PTR) ? '0 : rd_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_op;
    end
  end

endmodule

[sv/lrcv_back.sv]
module lrcv_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  lrcv_pkg::op_t    op,
  output logic             pop,
  lrcv_out_if.source       out_chan
);

  logic [63:0] seq_r, seq_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] idlen_r, idlen_nxt;
  logic [63:0] value_r, value_nxt;
  logic [15:0] strlen_r, strlen_nxt;
  logic [63:0] time_r, time_nxt;
  logic [31:0] scrc_r, scrc_nxt;
  logic [31:0] crc_r, crc_nxt, crc_cur;
  logic        halted_r, halted_nxt, halt_cur;

  logic        emit;
  logic [1:0]  kind_nxt;
  logic [7:0]  data_nxt;
  logic        ok_nxt;

  logic        ov_r;
  logic [1:0]  kind_r;
  logic [7:0]  data_r;
  logic [63:0] oseq_r, oval_r, otime_r;
  logic [7:0]  otype_r;
  logic [15:0] oidlen_r, ostrlen_r;
  logic        ok_r;

  assign pop = !q_empty && (!ov_r || out_chan.ready);

  // carry out one classified byte
  always_comb begin
    crc_cur    = op.start ? lrcv_pkg::CRC_ONES : crc_r;
    halt_cur   = op.start ? 1'b0 : halted_r;
    crc_nxt    = crc_cur;
    halted_nxt = halt_cur;
    seq_nxt    = seq_r;
    type_nxt   = type_r;
    idlen_nxt  = idlen_r;
    value_nxt  = value_r;
    strlen_nxt = strlen_r;
    time_nxt   = time_r;
    scrc_nxt   = scrc_r;
    emit       = 1'b0;
    kind_nxt   = lrcv_pkg::KIND_ID;
    data_nxt   = 8'd0;
    ok_nxt     = 1'b0;

    if (!halt_cur) begin
      if (op.crc_en) begin
        crc_nxt = lrcv_pkg::crc_byte(crc_cur, op.data);
      end
      case (op.ph)
        lrcv_pkg::PH_SEQ:    seq_nxt    = {op.data, seq_r[63:8]};
        lrcv_pkg::PH_TYPE:   type_nxt   = op.data;
        lrcv_pkg::PH_IDLEN:  idlen_nxt  = {op.data, idlen_r[15:8]};
        lrcv_pkg::PH_VALUE:  value_nxt  = {op.data, value_r[63:8]};
        lrcv_pkg::PH_STRLEN: strlen_nxt = {op.data, strlen_r[15:8]};
        lrcv_pkg::PH_ID, lrcv_pkg::PH_STR: begin
          emit     = 1'b1;
          kind_nxt = (op.ph == lrcv_pkg::PH_ID) ? lrcv_pkg::KIND_ID : lrcv_pkg::KIND_STR;
          data_nxt = op.data;
        end
        lrcv_pkg::PH_TAIL: begin
          if (op.crc_en) begin
            time_nxt = {op.data, time_r[63:8]};
          end else begin
            scrc_nxt = {op.data, scrc_r[31:8]};
          end
          if (op.last) begin
            ok_nxt     = ((crc_cur ^ lrcv_pkg::CRC_ONES) == scrc_nxt);
            emit       = 1'b1;
            kind_nxt   = lrcv_pkg::KIND_END;
            halted_nxt = !ok_nxt;
            crc_nxt    = lrcv_pkg::CRC_ONES;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= lrcv_pkg::CRC_ONES;
      halted_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      if (pop) begin
        crc_r    <= crc_nxt;
        halted_r <= halted_nxt;
      end
      if (pop && emit) begin
        ov_r <= 1'b1;
      end else if (out_chan.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // record fields and output register
  always_ff @(posedge clk) begin
    if (pop) begin
      seq_r    <= seq_nxt;
      type_r   <= type_nxt;
      idlen_r  <= idlen_nxt;
      value_r  <= value_nxt;
      strlen_r <= strlen_nxt;
      time_r   <= time_nxt;
      scrc_r   <= scrc_nxt;
    end
    if (pop && emit) begin
      kind_r    <= kind_nxt;
      data_r    <= data_nxt;
      ok_r      <= ok_nxt;
      if (kind_nxt == lrcv_pkg::KIND_END) begin
        oseq_r    <= seq_r;
        otype_r   <= type_r;
        oidlen_r  <= idlen_r;
        oval_r    <= value_r;
        ostrlen_r <= strlen_r;
        otime_r   <= time_nxt;
      end else begin
        oseq_r    <= 64'd0;
        otype_r   <= 8'd0;
        oidlen_r  <= 16'd0;
        oval_r    <= 64'd0;
        ostrlen_r <= 16'd0;
        otime_r   <= 64'd0;
      end
    end
  end

  assign out_chan.valid          = ov_r;
  assign out_chan.kind           = kind_r;
  assign out_chan.data_byte      = data_r;
  assign out_chan.sequence_res   = oseq_r;
  assign out_chan.entry_type     = otype_r;
  assign out_chan.id_length      = oidlen_r;
  assign out_chan.int_value      = oval_r;
  assign out_chan.string_length  = ostrlen_r;
  assign out_chan.timestamp_bits = otime_r;
  assign out_chan.crc_ok         = ok_r;

endmodule
